>>> sv/fds_pkg.sv
// ---------------------------------------------------------------------------
// fds_pkg
// Shared types and constants of the FAT directory name search block.
// ---------------------------------------------------------------------------
`default_nettype none

package fds_pkg;

    // Directory entry layout
    localparam logic [7:0] END_MARK     = 8'h00;
    localparam logic [7:0] DELETED_MARK = 8'hE5;
    localparam logic [4:0] CLUSTER_LO   = 5'h1A;
    localparam logic [4:0] CLUSTER_HI   = 5'h1B;
    localparam logic [4:0] SIZE_LO      = 5'h1C;
    localparam logic [4:0] ENTRY_LAST   = 5'h1F;
    localparam logic [4:0] NAME_BYTES   = 5'd11;
    localparam int         NAME_BITS    = 88;

    // Configuration register indexes
    localparam logic REG_NAME_BASE = 1'b0;
    localparam logic REG_NAME_EXT  = 1'b1;

    // Search outcome codes
    typedef enum logic [1:0] {
        OUTCOME_FOUND     = 2'd0,
        OUTCOME_END       = 2'd1,
        OUTCOME_EXHAUSTED = 2'd2
    } outcome_t;

    // One search result
    typedef struct packed {
        outcome_t    outcome;
        logic [15:0] start_cluster;
        logic [31:0] file_length;
        logic [7:0]  entry_number;
    } fds_result_t;

endpackage

`default_nettype wire

>>> sv/fds_scan.sv
// ---------------------------------------------------------------------------
// fds_scan
// Per-byte directory scan: offset and entry counters, name compare,
// cluster and size gathering, result decision.
// ---------------------------------------------------------------------------
`default_nettype none

module fds_scan
    import fds_pkg::*;
#(
    parameter int MAX_ENTRIES = 224
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 advance,
    input  wire logic [7:0]           dir_byte,
    input  wire logic                 first_byte,
    input  wire logic [NAME_BITS-1:0] name_all,
    output logic                      res_valid,
    output fds_result_t               res
);

    localparam logic [7:0] LAST_ENTRY = 8'(MAX_ENTRIES - 1);

    logic [4:0]  offset_reg, offset_next;
    logic [7:0]  count_reg, count_next;
    logic        match_reg, match_next;
    logic        skip_reg, skip_next;
    logic        finished_reg, finished_next;
    logic [15:0] cluster_reg, cluster_next;
    logic [31:0] size_reg, size_next;

    logic [7:0]  name_chars [16];

    // Split the configured name into characters, first character at index 0
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            if (i < 11)
            begin
                name_chars[i] = name_all[NAME_BITS - 1 - 8 * i -: 8];
            end
            else
            begin
                name_chars[i] = 8'h00;
            end
        end
    end

    // Next state and result for the byte being transferred
    always_comb
    begin
        logic [4:0] off;
        logic [7:0] cnt;
        logic       fin;
        offset_next   = offset_reg;
        count_next    = count_reg;
        match_next    = match_reg;
        skip_next     = skip_reg;
        finished_next = finished_reg;
        cluster_next  = cluster_reg;
        size_next     = size_reg;
        res_valid     = 1'b0;
        res           = '{outcome: OUTCOME_END, start_cluster: 16'h0000,
                          file_length: 32'h0000_0000, entry_number: 8'h00};
        off = first_byte ? 5'd0 : offset_reg;
        cnt = first_byte ? 8'd0 : count_reg;
        fin = first_byte ? 1'b0 : finished_reg;

        if (advance)
        begin
            offset_next   = off;
            count_next    = cnt;
            finished_next = fin;
            res.entry_number = cnt;

            if (!fin)
            begin
                // Open a new entry
                if (off == 5'd0)
                begin
                    match_next   = 1'b1;
                    skip_next    = (dir_byte == DELETED_MARK);
                    cluster_next = 16'h0000;
                    size_next    = 32'h0000_0000;
                end

                // Compare name characters
                if (off < NAME_BYTES && dir_byte != name_chars[off[3:0]])
                begin
                    match_next = 1'b0;
                end

                // Gather little-endian cluster and size
                if (off == CLUSTER_LO)
                begin
                    cluster_next[7:0] = dir_byte;
                end
                if (off == CLUSTER_HI)
                begin
                    cluster_next[15:8] = dir_byte;
                end
                if (off >= SIZE_LO)
                begin
                    unique case (off[1:0])
                        2'd0:    size_next[7:0]   = dir_byte;
                        2'd1:    size_next[15:8]  = dir_byte;
                        2'd2:    size_next[23:16] = dir_byte;
                        default: size_next[31:24] = dir_byte;
                    endcase
                end

                // Decide the outcome
                if (off == 5'd0 && dir_byte == END_MARK)
                begin
                    res_valid     = 1'b1;
                    res.outcome   = OUTCOME_END;
                    finished_next = 1'b1;
                end
                else if (off == ENTRY_LAST)
                begin
                    offset_next = 5'd0;
                    if (match_next && !skip_next)
                    begin
                        res_valid         = 1'b1;
                        res.outcome       = OUTCOME_FOUND;
                        res.start_cluster = cluster_next;
                        res.file_length   = size_next;
                        finished_next     = 1'b1;
                    end
                    else if (cnt >= LAST_ENTRY)
                    begin
                        res_valid     = 1'b1;
                        res.outcome   = OUTCOME_EXHAUSTED;
                        finished_next = 1'b1;
                    end
                    else
                    begin
                        count_next = cnt + 8'd1;
                    end
                end
                else
                begin
                    offset_next = off + 5'd1;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg   <= 5'd0;
            count_reg    <= 8'd0;
            match_reg    <= 1'b1;
            skip_reg     <= 1'b0;
            finished_reg <= 1'b1;
            cluster_reg  <= 16'h0000;
            size_reg     <= 32'h0000_0000;
        end
        else
        begin
            offset_reg   <= offset_next;
            count_reg    <= count_next;
            match_reg    <= match_next;
            skip_reg     <= skip_next;
            finished_reg <= finished_next;
            cluster_reg  <= cluster_next;
            size_reg     <= size_next;
        end
    end

    // A result always closes the search
    a_result_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> finished_reg)
        else $error("search still open after a result");

    // The entry counter never passes the last entry
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LAST_ENTRY)
        else $error("entry counter beyond the last entry");

    // A result only comes with a byte that advances
    a_result_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> advance)
        else $error("result without an advancing byte");

endmodule

`default_nettype wire

>>> sv/fds_out_buf.sv
// ---------------------------------------------------------------------------
// fds_out_buf
// Two-slot result buffer: output register plus skid slot, so the scan
// keeps taking bytes while a result waits.
// ---------------------------------------------------------------------------
`default_nettype none

module fds_out_buf
    import fds_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire fds_result_t push_data,
    output logic       room,
    output logic       out_valid,
    input  wire logic  out_ready,
    output fds_result_t out_data
);

    logic [1:0]  count_reg, count_next;
    fds_result_t slot0_reg, slot0_next;
    fds_result_t slot1_reg, slot1_next;
    logic        pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot0_reg;
    assign room      = (count_reg != 2'd2);

    // Shift on transfer out, fill the first free slot on push
    always_comb
    begin
        count_next = count_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (pop)
        begin
            slot0_next = slot1_reg;
        end
        if (push)
        begin
            if (count_reg == 2'd0 || (count_reg == 2'd1 && pop))
            begin
                slot0_next = push_data;
            end
            else
            begin
                slot1_next = push_data;
            end
        end
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    // Never push into a full buffer
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> room)
        else $error("result pushed into a full buffer");

    // Fill level stays within two slots
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result buffer fill level out of range");

    // A full buffer always offers a result
    a_full_offers: assert property (@(posedge clk) disable iff (!rst_n)
        !room |-> out_valid)
        else $error("full result buffer not offering a result");

endmodule

`default_nettype wire

>>> sv/fat_directory_name_search.sv
// ---------------------------------------------------------------------------
// fat_directory_name_search
// Scans FAT root directory bytes for one configured 8.3 name and reports
// start cluster and file size, end of directory, or exhaustion.
// ---------------------------------------------------------------------------
//  channel   handshake              payload
//  in        in_valid / in_ready    dir_byte, first_byte
//  out       out_valid / out_ready  outcome, start_cluster, file_length,
//                                   entry_number
//  cfg       cfg_wr_en              cfg_index, cfg_data
//
//  One byte per cycle while the result buffer has room: an input register,
//  the scan logic, then a two-slot result buffer. A result enters the
//  buffer as its byte leaves the input register and is offered from there.
//  The two-slot buffer sets the rate under stalls: bytes keep flowing while
//  one result waits, and the input stalls only when both slots hold results.
//  Reset clears the search to idle; a byte with first_byte set starts it.
// ---------------------------------------------------------------------------
`default_nettype none

module fat_directory_name_search
    import fds_pkg::*;
#(
    parameter int MAX_ENTRIES = 224
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  dir_byte,
    input  wire logic        first_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       outcome,
    output logic [15:0]      start_cluster,
    output logic [31:0]      file_length,
    output logic [7:0]       entry_number,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [63:0] cfg_data
);

    logic [63:0] name_base_reg;
    logic [23:0] name_ext_reg;
    logic        stage_valid_reg;
    logic [7:0]  stage_byte_reg;
    logic        stage_first_reg;
    logic        room;
    logic        advance;
    logic        res_valid;
    fds_result_t res;
    fds_result_t out_data;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_base_reg <= 64'h0;
            name_ext_reg  <= 24'h0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_NAME_BASE: name_base_reg <= cfg_data;
                REG_NAME_EXT:  name_ext_reg  <= cfg_data[23:0];
            endcase
        end
    end

    // Input register: advance when the result buffer has room
    assign advance  = stage_valid_reg && room;
    assign in_ready = !stage_valid_reg || room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            stage_byte_reg  <= dir_byte;
            stage_first_reg <= first_byte;
        end
    end

    fds_scan #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .dir_byte   (stage_byte_reg),
        .first_byte (stage_first_reg),
        .name_all   ({name_base_reg, name_ext_reg}),
        .res_valid  (res_valid),
        .res        (res)
    );

    fds_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Drive result ports
    assign outcome       = out_data.outcome;
    assign start_cluster = out_data.start_cluster;
    assign file_length   = out_data.file_length;
    assign entry_number  = out_data.entry_number;

endmodule

`default_nettype wire

>>> test/fat_directory_name_search_tb.sv
// ---------------------------------------------------------------------------
// fat_directory_name_search_tb
// Self-checking bench for the FAT directory name search. A directed table
// covers idle bytes, end markers, deleted entries, restarts, a name change
// within a search and all-zero/all-one values. Random directories follow.
// Typed table rows are checked against the table, the rest against a scan
// model of the block; both channels see random gaps and one long output stall.
// ---------------------------------------------------------------------------
`default_nettype none

module fat_directory_name_search_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import fds_pkg::*;

    localparam int MAX_ENTRIES   = 224;
    localparam int RANDOM_ITEMS  = 330;
    localparam int RANDOM_FINDS  = 4;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 300;
    localparam int MAX_REPORTS   = 10;
    localparam int PLAN_ROWS     = 24;

    // Names used by the directed table
    localparam logic [87:0] NAME_KERNEL = "KERNEL  BIN";
    localparam logic [87:0] NAME_README = "README  TXT";
    localparam logic [87:0] NAME_ERASED = {DELETED_MARK, "ERNEL  BIN"};
    localparam logic [87:0] NAME_OLD    = "ABCDEFGHBIN";
    localparam logic [87:0] NAME_MIXED  = "ABCDWXYZBIN";
    localparam logic [87:0] NAME_NEW    = "ZZZZWXYZBIN";
    localparam logic [87:0] NAME_ONES   = {11{8'hFF}};
    localparam logic [87:0] NAME_ZERO   = 88'd0;
    localparam logic [87:0] BYTE_A      = {"A", 80'd0};
    localparam logic [87:0] BYTE_END    = {END_MARK, 80'd0};

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_BYTE,
        ROW_ENTRY,
        ROW_FILL
    } row_kind_t;

    // One directed row: a register write, a single byte, part of an entry,
    // or a run of non-matching entries (count held in hi)
    typedef struct {
        row_kind_t   kind;
        logic        first;
        logic [87:0] name;
        logic [15:0] cluster;
        logic [31:0] size;
        int          lo;
        int          hi;
        bit          typed;
        outcome_t    outcome;
        logic [7:0]  entry;
    } dir_row_t;

    dir_row_t plan [PLAN_ROWS] = '{
        '{ROW_CFG,   1'b0, NAME_KERNEL, 16'h0000, 32'h0000_0000, 0, 0,  1'b0, OUTCOME_FOUND, 8'd0},
        '{ROW_BYTE,  1'b0, BYTE_A,      16'h0000, 32'h0000_0000, 0, 0,  1'b0, OUTCOME_FOUND, 8'd0},
        '{ROW_BYTE,  1'b1, BYTE_END,    16'h0000, 32'h0000_0000, 0, 0,  1'b1, OUTCOME_END,   8'd0},
        '{ROW_BYTE,  1'b0, BYTE_END,    16'h0000, 32'h0000_0000, 0, 0,  1'b0, OUTCOME_FOUND, 8'd0},
        '{ROW_ENTRY, 1'b1, NAME_KERNEL, 16'h0002, 32'h0000_1234, 0, 31, 1'b1, OUTCOME_FOUND, 8'd0},
        '{ROW_ENTRY, 1'b1, NAME_README, 16'h1111, 32'h2222_2222, 0, 31, 1'b0, OUTCOME_FOUND, 8'd0},
        '{ROW_ENTRY, 1'b0, NAME_KERNEL, 16'hFFFF, 32'hFFFF_FFFF, 0, 31, 1'b1, OUTCOME_FOUND, 8'd1},
        '{ROW_ENTRY, 1'b1, NAME_KERNEL, 16'h3333, 32'h4444_4444, 0, 12, 1'b0, OUTCOME_FOUND, 8'd0},
        '{ROW_ENTRY, 1'b1, NAME_KERNEL, 16'h0000, 32'h0000_0000, 0, 31, 1'b1, OUTCOME_FOUND, 8'd0},
        '{ROW_CFG,   1'b0, NAME_ERASED, 16'h0000, 32'h0000_0000, 0, 0,  1'b0, OUTCOME_FOUND, 8'd0},
        '{ROW_ENTRY, 1'b1, NAME_ERASED, 16'h5555, 32'h6666_6666, 0, 31, 1'b0, OUTCOME_FOUND, 8'd0},
        '{ROW_BYTE,  1'b0, BYTE_END,    16'h0000, 32'h0000_0000, 0, 0,  1'b1, OUTCOME_END,   8'd1},
        '{ROW_CFG,   1'b0, NAME_OLD,    16'h0000, 32'h0000_0000, 0, 0,  1'b0, OUTCOME_FOUND, 8'd0},
        '{ROW_ENTRY, 1'b1, NAME_MIXED,  16'h1357, 32'h2468_ACE0, 0, 3,  1'b0, OUTCOME_FOUND, 8'd0},
        '{ROW_CFG,   1'b0, NAME_NEW,    16'h0000, 32'h0000_0000, 0, 0,  1'b0, OUTCOME_FOUND, 8'd0},
        '{ROW_ENTRY, 1'b0, NAME_MIXED,  16'h1357, 32'h2468_ACE0, 4, 31, 1'b0, OUTCOME_FOUND, 8'd0},
        '{ROW_FILL,  1'b1, NAME_ZERO,   16'h0000, 32'h0000_0000, 0, 3,  1'b0, OUTCOME_FOUND, 8'd0},
        '{ROW_BYTE,  1'b0, BYTE_END,    16'h0000, 32'h0000_0000, 0, 0,  1'b1, OUTCOME_END,   8'd3},
        '{ROW_CFG,   1'b0, NAME_ONES,   16'h0000, 32'h0000_0000, 0, 0,  1'b0, OUTCOME_FOUND, 8'd0},
        '{ROW_ENTRY, 1'b1, NAME_ONES,   16'hFFFF, 32'h0000_0000, 0, 31, 1'b1, OUTCOME_FOUND, 8'd0},
        '{ROW_BYTE,  1'b0, BYTE_END,    16'h0000, 32'h0000_0000, 0, 0,  1'b0, OUTCOME_FOUND, 8'd0},
        '{ROW_CFG,   1'b0, NAME_ZERO,   16'h0000, 32'h0000_0000, 0, 0,  1'b0, OUTCOME_FOUND, 8'd0},
        '{ROW_ENTRY, 1'b1, NAME_KERNEL, 16'h7777, 32'h8888_8888, 0, 31, 1'b0, OUTCOME_FOUND, 8'd0},
        '{ROW_BYTE,  1'b0, BYTE_END,    16'h0000, 32'h0000_0000, 0, 0,  1'b1, OUTCOME_END,   8'd1}
    };

    // DUT connections; the bench's inputs are driven from time zero
    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [7:0]  dir_byte   = 8'd0;
    logic        first_byte = 1'b0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [1:0]  outcome;
    logic [15:0] start_cluster;
    logic [31:0] file_length;
    logic [7:0]  entry_number;
    logic        cfg_wr_en  = 1'b0;
    logic        cfg_index  = REG_NAME_BASE;
    logic [63:0] cfg_data   = 64'd0;

    // Scan model state
    logic [87:0] target_name    = 88'd0;
    logic [4:0]  scan_ofs       = 5'd0;
    logic [7:0]  scan_entry     = 8'd0;
    logic        scan_match     = 1'b1;
    logic        scan_deleted   = 1'b0;
    logic        scan_idle      = 1'b1;
    logic [15:0] gather_cluster = 16'd0;
    logic [31:0] gather_size    = 32'd0;

    fds_result_t pending_lookups[$];
    fds_result_t typed_want;
    bit          typed_armed   = 1'b0;
    bit          tx_steady     = 1'b0;
    bit          rx_steady     = 1'b0;
    bit          hold_request  = 1'b0;
    int          mismatch_count = 0;
    int          fed_items     = 0;
    int          lookups_made  = 0;

    fat_directory_name_search #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .dir_byte(dir_byte),
        .first_byte(first_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .outcome(outcome),
        .start_cluster(start_cluster),
        .file_length(file_length),
        .entry_number(entry_number),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Free-running clock
    initial
    begin
        forever #10 clk = ~clk;
    end

    // Hard stop
    initial
    begin
        #50_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Random search name: extremes, raw bits, or space-padded letters
    function automatic logic [87:0] pick_name();
        logic [87:0] nm;
        int          r;
        int          base_len;
        int          ext_len;
        r = $urandom_range(0, 19);
        if (r == 0)
            return NAME_ONES;
        if (r == 1)
            return NAME_ZERO;
        if (r < 5)
            return 88'({$urandom, $urandom, $urandom});
        nm = {11{8'h20}};
        base_len = $urandom_range(1, 8);
        ext_len = $urandom_range(0, 3);
        for (int k = 0; k < base_len; k++)
            nm[87 - 8 * k -: 8] = 8'(8'h41 + $urandom_range(0, 25));
        for (int k = 0; k < ext_len; k++)
            nm[23 - 8 * k -: 8] = 8'(8'h41 + $urandom_range(0, 25));
        return nm;
    endfunction

    // Advance the scan model by one directory byte
    task automatic scan_byte(input logic [7:0] b, input logic f, output bit taken,
                             output bit found, output fds_result_t res);
        int ofs;
        taken = 1'b0;
        found = 1'b0;
        res = '0;
        if (f)
        begin
            scan_ofs = 5'd0;
            scan_entry = 8'd0;
            scan_idle = 1'b0;
        end
        if (scan_idle)
            return;
        taken = 1'b1;
        ofs = int'(scan_ofs);

        // Open a new entry; an end marker closes the search at once
        if (ofs == 0)
        begin
            scan_match = 1'b1;
            scan_deleted = 1'b0;
            gather_cluster = 16'd0;
            gather_size = 32'd0;
            if (b == END_MARK)
            begin
                res.outcome = OUTCOME_END;
                res.entry_number = scan_entry;
                found = 1'b1;
                scan_idle = 1'b1;
                return;
            end
            if (b == DELETED_MARK)
                scan_deleted = 1'b1;
        end

        // Compare name bytes, gather cluster and size
        if (ofs < int'(NAME_BYTES) && b != target_name[NAME_BITS - 1 - 8 * ofs -: 8])
            scan_match = 1'b0;
        if (ofs == int'(CLUSTER_LO))
            gather_cluster[7:0] = b;
        if (ofs == int'(CLUSTER_HI))
            gather_cluster[15:8] = b;
        if (ofs >= int'(SIZE_LO))
            gather_size[8 * (ofs - int'(SIZE_LO)) +: 8] = b;

        // Close the entry
        if (ofs == int'(ENTRY_LAST))
        begin
            scan_ofs = 5'd0;
            if (scan_match && !scan_deleted)
            begin
                res.outcome = OUTCOME_FOUND;
                res.start_cluster = gather_cluster;
                res.file_length = gather_size;
                res.entry_number = scan_entry;
                found = 1'b1;
                scan_idle = 1'b1;
            end
            else if (int'(scan_entry) >= MAX_ENTRIES - 1)
            begin
                res.outcome = OUTCOME_EXHAUSTED;
                res.entry_number = scan_entry;
                found = 1'b1;
                scan_idle = 1'b1;
            end
            else
                scan_entry = scan_entry + 8'd1;
        end
        else
            scan_ofs = 5'(ofs + 1);
    endtask

    // Offer one byte, hold it until the transfer, then predict
    task automatic send_byte(input logic [7:0] b, input logic f);
        int          gap;
        bit          taken;
        bit          found;
        fds_result_t res;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        dir_byte <= b;
        first_byte <= f;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        scan_byte(b, f, taken, found, res);
        if (taken)
            fed_items++;
        if (found)
        begin
            lookups_made++;
            if (typed_armed)
            begin
                pending_lookups.push_back(typed_want);
                typed_armed = 1'b0;
            end
            else
                pending_lookups.push_back(res);
        end
    endtask

    // Send bytes lo..hi of one 32-byte entry; filler bytes are random
    task automatic send_entry(input logic [87:0] nm, input logic [15:0] cluster,
                              input logic [31:0] size, input logic f,
                              input int lo, input int hi);
        logic [7:0] b;
        for (int o = lo; o <= hi; o++)
        begin
            if (o < int'(NAME_BYTES))
                b = nm[NAME_BITS - 1 - 8 * o -: 8];
            else if (o == int'(CLUSTER_LO))
                b = cluster[7:0];
            else if (o == int'(CLUSTER_HI))
                b = cluster[15:8];
            else if (o >= int'(SIZE_LO))
                b = size[8 * (o - int'(SIZE_LO)) +: 8];
            else
                b = 8'($urandom_range(0, 255));
            send_byte(b, f && o == lo);
        end
    endtask

    // Send entries that cannot match: first byte differs from the target
    task automatic fill_entries(input int count, input logic f);
        logic [87:0] nm;
        for (int i = 0; i < count; i++)
        begin
            do
                nm = 88'({$urandom, $urandom, $urandom});
            while (nm[87:80] == END_MARK || nm[87:80] == DELETED_MARK ||
                   nm[87:80] == target_name[87:80]);
            send_entry(nm, 16'($urandom), $urandom, f && i == 0, 0, 31);
        end
    endtask

    // Drop valid, wait for all results, then let the pipeline settle
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both name registers; junk above the extension field
    task automatic write_regs(input logic [87:0] nm);
        logic [63:0] ext_word;
        ext_word = {$urandom, $urandom};
        ext_word[23:0] = nm[23:0];
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_NAME_BASE;
        cfg_data <= nm[87:24];
        @(posedge clk);
        cfg_index <= REG_NAME_EXT;
        cfg_data <= ext_word;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        target_name = nm;
        @(posedge clk);
    endtask

    // One random directory: a few decoys, then the target, an end marker,
    // a broken entry or noise; the name may change between entries
    task automatic random_directory();
        logic [87:0] nm;
        logic        lead;
        int          decoys;
        int          fate;
        int          pos;
        lead = 1'b1;
        decoys = $urandom_range(0, 4);
        for (int i = 0; i < decoys; i++)
        begin
            if (!lead && $urandom_range(0, 11) == 0)
            begin
                drain();
                write_regs(pick_name());
            end
            case ($urandom_range(0, 2))
                0:
                begin
                    do
                        nm = 88'({$urandom, $urandom, $urandom});
                    while (nm[87:80] == END_MARK);
                end
                1:
                    nm = {DELETED_MARK, target_name[79:0]};
                default:
                begin
                    nm = target_name;
                    pos = $urandom_range(0, int'(NAME_BYTES) - 1);
                    nm[8 * pos + $urandom_range(0, 7)] ^= 1'b1;
                end
            endcase
            send_entry(nm, 16'($urandom), $urandom, lead, 0, 31);
            lead = 1'b0;
        end
        fate = $urandom_range(0, 99);
        if (fate < 55)
            send_entry(target_name, 16'($urandom), $urandom, lead, 0, 31);
        else if (fate < 80)
            send_byte(END_MARK, lead);
        else if (fate < 90)
            send_entry(88'({$urandom, $urandom, $urandom}), 16'($urandom), $urandom,
                       lead, 0, $urandom_range(0, 30));
        else
        begin
            repeat ($urandom_range(1, 12))
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
        end
    endtask

    // Check each output transfer against the oldest prediction
    task automatic compare_lookup();
        fds_result_t want;
        if (pending_lookups.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("unexpected result: outcome %0d cluster %h length %h entry %0d",
                         outcome, start_cluster, file_length, entry_number);
            return;
        end
        want = pending_lookups.pop_front();
        if (outcome !== want.outcome || start_cluster !== want.start_cluster ||
            file_length !== want.file_length || entry_number !== want.entry_number)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("result mismatch: expected %0d/%h/%h/%0d got %0d/%h/%h/%0d",
                         want.outcome, want.start_cluster, want.file_length,
                         want.entry_number, outcome, start_cluster, file_length,
                         entry_number);
        end
    endtask

    // Sample output transfers
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            compare_lookup();
    end

    // Receiver: random stalls, plus one long hold on request
    initial
    begin : receiver
        int stall_left;
        int len;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                len = rx_steady ? 0 : pick_gap();
                if (len > 0 && $urandom_range(0, 2) == 0)
                begin
                    out_ready <= 1'b0;
                    stall_left = len - 1;
                end
                else
                    out_ready <= 1'b1;
            end
        end
    end

    // Main sequence: reset, directed table, random directories, wind-down
    initial
    begin
        int fed_mark;
        int made_mark;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (plan[i])
        begin
            typed_want = '0;
            typed_want.outcome = plan[i].outcome;
            typed_want.entry_number = plan[i].entry;
            if (plan[i].outcome == OUTCOME_FOUND)
            begin
                typed_want.start_cluster = plan[i].cluster;
                typed_want.file_length = plan[i].size;
            end
            typed_armed = plan[i].typed;
            case (plan[i].kind)
                ROW_CFG:
                begin
                    drain();
                    write_regs(plan[i].name);
                end
                ROW_BYTE:
                    send_byte(plan[i].name[87:80], plan[i].first);
                ROW_ENTRY:
                    send_entry(plan[i].name, plan[i].cluster, plan[i].size, plan[i].first,
                               plan[i].lo, plan[i].hi);
                default:
                    fill_entries(plan[i].hi, plan[i].first);
            endcase
            typed_armed = 1'b0;
        end

        // Fill the result buffer against a long output hold
        drain();
        tx_steady = 1'b1;
        hold_request = 1'b1;
        repeat (16)
            send_byte(END_MARK, 1'b1);
        tx_steady = 1'b0;

        // Random directories until enough bytes and results have gone through
        fed_mark = fed_items;
        made_mark = lookups_made;
        while (fed_items - fed_mark < RANDOM_ITEMS || lookups_made - made_mark < RANDOM_FINDS)
        begin
            tx_steady = $urandom_range(0, 5) == 0;
            rx_steady = $urandom_range(0, 5) == 0;
            if ($urandom_range(0, 3) == 0)
            begin
                drain();
                write_regs(pick_name());
            end
            random_directory();
        end

        drain();
        if (mismatch_count == 0 && pending_lookups.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
